// ===== hw/rtl/wrv_pkg.sv =====
// shared types and constants of the windowed regression velocity estimator
`timescale 1ns / 1ps

package wrv_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned VEL_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned WIN_W      = 5;
  localparam int unsigned SF_W       = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned QUO_W      = 33;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH = 1'd1;

  localparam logic [WIN_W-1:0] WIN_RESET = 5'd5;
  localparam logic [SF_W-1:0]  SF_RESET  = 17'd52429;
  localparam logic [SF_W-1:0]  SF_ONE    = 17'h10000;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DEGEN = 2'd2;

  localparam int unsigned DEN_MIN   = 1000;
  localparam int unsigned US_PER_S  = 1000000;
  localparam int unsigned EMA_ROUND = 32768;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [TIME_W-1:0]       sample_time;
  } in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [STATUS_W-1:0]     status;
  } out_t;

endpackage

// ===== hw/rtl/wrv_ram.sv =====
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module wrv_ram #(
  parameter int unsigned DW    = 128,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/wrv_mul.sv =====
// bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module wrv_mul #(
  parameter int unsigned A_W = 75,
  parameter int unsigned B_W = 37
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned P_W = A_W + B_W;
  localparam int unsigned C_W = $clog2(B_W + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [C_W-1:0] cnt_q, cnt_d;
  logic [P_W-1:0] acc_q, acc_d;
  logic [P_W-1:0] ash_q, ash_d;
  logic [B_W-1:0] bsh_q, bsh_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    ash_d  = ash_q;
    bsh_d  = bsh_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = C_W'(B_W);
      acc_d  = '0;
      ash_d  = P_W'(a_i);
      bsh_d  = b_i;
    end else if (busy_q) begin
      if (bsh_q[0]) begin
        acc_d = acc_q + ash_q;
      end
      ash_d = {ash_q[P_W-2:0], 1'b0};
      bsh_d = {1'b0, bsh_q[B_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == C_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ash_q <= ash_d;
    bsh_q <= bsh_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/wrv_div.sv =====
// restoring divider, one quotient bit per cycle, with early overflow detect
`timescale 1ns / 1ps

module wrv_div #(
  parameter int unsigned N_W = 112,
  parameter int unsigned D_W = 75
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [N_W-1:0]           num_i,
  input  logic [D_W-1:0]           den_i,
  output logic                     done_o,
  output logic                     ovf_o,
  output logic [wrv_pkg::QUO_W-1:0] quo_o
);

  localparam int unsigned Q_W  = wrv_pkg::QUO_W;
  localparam int unsigned HI_W = N_W - Q_W;
  localparam int unsigned C_W  = $clog2(Q_W + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic           ovf_q, ovf_d;
  logic [C_W-1:0] cnt_q, cnt_d;
  logic [D_W-1:0] rem_q, rem_d;
  logic [D_W-1:0] den_q, den_d;
  logic [Q_W-1:0] low_q, low_d;
  logic [Q_W-1:0] quo_q, quo_d;

  logic [HI_W-1:0] num_hi;
  logic [D_W:0]    trial;
  logic [D_W:0]    diff;
  logic            ge;

  assign num_hi = num_i[N_W-1:Q_W];
  assign trial  = {rem_q, low_q[Q_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quo_d  = quo_q;
    if (start_i) begin
      den_d = den_i;
      quo_d = '0;
      low_d = num_i[Q_W-1:0];
      rem_d = num_hi[D_W-1:0];
      cnt_d = C_W'(Q_W);
      // quotient would need more bits than kept: result saturates anyway
      if (num_hi >= HI_W'(den_i)) begin
        ovf_d  = 1'b1;
        done_d = 1'b1;
      end else begin
        ovf_d  = 1'b0;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_d = {quo_q[Q_W-2:0], ge};
      low_d = {low_q[Q_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == C_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

// ===== hw/rtl/window_regression_velocity.sv =====
// Windowed least-squares velocity estimator with exponential smoothing.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one timestamped 3-D position per
// transfer; output channel (out_valid_o/out_ready_i/out_data_o) returns one velocity and a
// status for each input. Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i:
// index 0 window size, index 1 smoothing weight. The user must write them only while
// the block is idle; the block itself does not enforce this. Samples live in a ring ram
// of WINDOW_MAX entries. Per item the block writes the sample, streams the n held samples
// out of the ram to build the running sums, then forms the slope numerators and
// denominator on one shared bit-serial multiplier (11 products) and one bit-serial
// divider (3 quotients), and smooths the three axes; fewer than two held samples or
// degenerate timing skip straight to smoothing.
// One item is worked on at a time; a new item is taken as soon as the previous result is
// in the output register, even if the receiver has not yet taken it. A stalled receiver
// holds the output register and the finished next result waits in the block.
// Reset clears the sample count, ring pointer, smoothed velocities and registers to their
// defaults; the history ram is not cleared since only written entries are ever read.
`timescale 1ns / 1ps

module window_regression_velocity #(
  parameter int unsigned WINDOW_MAX = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  wrv_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output wrv_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [wrv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wrv_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(WINDOW_MAX);
  localparam int unsigned NW    = $clog2(WINDOW_MAX + 1);
  localparam int unsigned ST_W  = 32 + NW;
  localparam int unsigned T2_W  = 64 + NW;
  localparam int unsigned ACC_W = 65 + 2 * NW;
  localparam int unsigned PW    = ACC_W + ST_W;
  localparam int unsigned DW    = $bits(wrv_pkg::in_t);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_EMA  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    M_NST2  = 5'b00001,
    M_STST  = 5'b00010,
    M_NSTP  = 5'b00100,
    M_STSP  = 5'b01000,
    M_SCALE = 5'b10000
  } mop_e;

  state_e state_q, state_d;
  mop_e   mop_q, mop_d;

  logic [wrv_pkg::WIN_W-1:0] win_q, win_d;
  logic [wrv_pkg::SF_W-1:0]  sf_q, sf_d;
  logic [NW-1:0]             cnt_q, cnt_d;
  logic [AW-1:0]             wslot_q, wslot_d;
  logic signed [31:0]        smooth_q [3];
  logic signed [31:0]        smooth_d [3];

  // sample stream
  logic [NW-1:0]      issue_q, issue_d;
  logic [AW-1:0]      rd_addr_q, rd_addr_d;
  logic               r1_v_q, r1_v_d, r1_first_q, r1_first_d;
  logic [31:0]        ref_q, ref_d;
  logic               a_v_q, a_v_d;
  logic [31:0]        relt_q, relt_d;
  logic signed [31:0] apos_q [3];
  logic signed [31:0] apos_d [3];
  logic               b_v_q, b_v_d;
  logic [31:0]        brelt_q, brelt_d;
  logic [63:0]        t2_q, t2_d;
  logic signed [63:0] tp_q [3];
  logic signed [63:0] tp_d [3];
  logic signed [31:0] bpos_q [3];
  logic signed [31:0] bpos_d [3];

  // running sums
  logic [ST_W-1:0]        st_q, st_d;
  logic [T2_W-1:0]        st2_q, st2_d;
  logic signed [ST_W-1:0] sp_q [3];
  logic signed [ST_W-1:0] sp_d [3];
  logic signed [T2_W-1:0] stp_q [3];
  logic signed [T2_W-1:0] stp_d [3];

  // slope evaluation
  logic [ACC_W-1:0]        dena_q, dena_d;
  logic [ACC_W-1:0]        den_q, den_d;
  logic signed [ACC_W-1:0] term_q, term_d;
  logic [ACC_W-1:0]        nmag_q, nmag_d;
  logic                    nneg_q, nneg_d;
  logic [1:0]              axis_q, axis_d;
  logic signed [31:0]      raw_q [3];
  logic signed [31:0]      raw_d [3];
  logic [wrv_pkg::STATUS_W-1:0] status_q, status_d;
  logic                    mul_go_q, mul_go_d;
  logic                    div_go_q, div_go_d;

  // smoothing
  logic                    ema_ph_q, ema_ph_d;
  logic signed [49:0]      m1_q, m1_d, m2_q, m2_d;
  logic signed [31:0]      res_q [3];
  logic signed [31:0]      res_d [3];

  logic                    out_valid_q, out_valid_d;
  wrv_pkg::out_t           out_q, out_d;

  // ram and arithmetic units
  wrv_pkg::in_t   rd_data;
  logic [DW-1:0]  rd_raw;
  logic           ram_we;
  logic [ACC_W-1:0] mul_a;
  logic [ST_W-1:0]  mul_b;
  logic           mul_done;
  logic [PW-1:0]  mul_prod;
  logic           div_done, div_ovf;
  logic [wrv_pkg::QUO_W-1:0] div_quo;

  logic                    accept;
  logic [NW-1:0]           eff;
  logic [NW:0]             cnt_inc;
  logic [NW-1:0]           cnt_new;
  logic [AW-1:0]           wslot_new;
  logic [NW:0]             first_tmp;
  logic                    issue;
  logic [31:0]             base_t;
  logic signed [64:0]      tp_full [3];
  logic [ACC_W-1:0]        prod;
  logic [ACC_W-1:0]        den_new;
  logic signed [ACC_W-1:0] part2;
  logic signed [ACC_W-1:0] num_new;
  logic [ST_W-1:0]         sp_mag;
  logic [T2_W-1:0]         stp_mag;
  logic signed [31:0]      raw_new;
  logic                    sf_on;
  logic [wrv_pkg::SF_W-1:0] sf_inv;
  logic signed [50:0]      ema_sum;
  logic signed [34:0]      ema_v;
  logic signed [31:0]      ema_sat;

  assign rd_data = wrv_pkg::in_t'(rd_raw);
  assign accept  = in_valid_i && in_ready_o;
  assign ram_we  = accept;
  assign issue   = (state_q == S_READ) && (issue_q != cnt_q);
  assign sf_on   = (sf_q != '0) && !sf_q[wrv_pkg::SF_W-1];
  assign sf_inv  = wrv_pkg::SF_ONE - sf_q;
  assign prod    = mul_prod[ACC_W-1:0];
  assign sp_mag  = sp_q[axis_q][ST_W-1] ? ST_W'(-sp_q[axis_q]) : ST_W'(sp_q[axis_q]);
  assign stp_mag = stp_q[axis_q][T2_W-1] ? T2_W'(-stp_q[axis_q]) : T2_W'(stp_q[axis_q]);

  wrv_ram #(
    .DW   (DW),
    .DEPTH(WINDOW_MAX)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wslot_q),
    .wdata_i(DW'(in_data_i)),
    .raddr_i(rd_addr_q),
    .rdata_o(rd_raw)
  );

  always_comb begin
    unique case (mop_q)
      M_NST2: begin
        mul_a = ACC_W'(st2_q);
        mul_b = ST_W'(cnt_q);
      end
      M_STST: begin
        mul_a = ACC_W'(st_q);
        mul_b = st_q;
      end
      M_NSTP: begin
        mul_a = ACC_W'(stp_mag);
        mul_b = ST_W'(cnt_q);
      end
      M_STSP: begin
        mul_a = ACC_W'(st_q);
        mul_b = sp_mag;
      end
      M_SCALE: begin
        mul_a = nmag_q;
        mul_b = ST_W'(wrv_pkg::US_PER_S);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wrv_mul #(
    .A_W(ACC_W),
    .B_W(ST_W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_go_q),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  wrv_div #(
    .N_W(PW),
    .D_W(ACC_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go_q),
    .num_i  (mul_prod),
    .den_i  (den_q),
    .done_o (div_done),
    .ovf_o  (div_ovf),
    .quo_o  (div_quo)
  );

  // window bookkeeping for the incoming sample
  always_comb begin
    if (int'(win_q) > WINDOW_MAX) begin
      eff = NW'(WINDOW_MAX);
    end else if (win_q == '0) begin
      eff = NW'(1);
    end else begin
      eff = NW'(win_q);
    end
    cnt_inc   = {1'b0, cnt_q} + 1'b1;
    cnt_new   = (cnt_inc > {1'b0, eff}) ? eff : cnt_inc[NW-1:0];
    wslot_new = (wslot_q == AW'(WINDOW_MAX - 1)) ? '0 : wslot_q + 1'b1;
    first_tmp = (NW+1)'(wslot_new) + (NW+1)'(WINDOW_MAX) - {1'b0, cnt_new};
    if (first_tmp >= (NW+1)'(WINDOW_MAX)) begin
      first_tmp = first_tmp - (NW+1)'(WINDOW_MAX);
    end
  end

  // slope and smoothing arithmetic
  always_comb begin
    den_new = dena_q - prod;
    part2   = sp_q[axis_q][ST_W-1] ? -$signed(prod) : $signed(prod);
    num_new = term_q - part2;
    if (!nneg_q) begin
      if (div_ovf || div_quo > 33'h0_7FFF_FFFF) begin
        raw_new = 32'sh7FFF_FFFF;
      end else begin
        raw_new = $signed(div_quo[31:0]);
      end
    end else begin
      if (div_ovf || div_quo > 33'h0_8000_0000) begin
        raw_new = 32'sh8000_0000;
      end else begin
        raw_new = -$signed(div_quo[31:0]);
      end
    end
    ema_sum = {m1_q[49], m1_q} + {m2_q[49], m2_q} + 51'(wrv_pkg::EMA_ROUND);
    ema_v   = ema_sum[50:16];
    if (ema_v[34:31] == 4'b0000 || ema_v[34:31] == 4'b1111) begin
      ema_sat = ema_v[31:0];
    end else if (ema_v[34]) begin
      ema_sat = 32'sh8000_0000;
    end else begin
      ema_sat = 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    base_t = r1_first_q ? rd_data.sample_time : ref_q;
    for (int k = 0; k < 3; k++) begin
      tp_full[k] = $signed({1'b0, relt_q}) * apos_q[k];
    end
  end

  always_comb begin
    state_d     = state_q;
    mop_d       = mop_q;
    win_d       = win_q;
    sf_d        = sf_q;
    cnt_d       = cnt_q;
    wslot_d     = wslot_q;
    issue_d     = issue_q;
    rd_addr_d   = rd_addr_q;
    ref_d       = ref_q;
    st_d        = st_q;
    st2_d       = st2_q;
    dena_d      = dena_q;
    den_d       = den_q;
    term_d      = term_q;
    nmag_d      = nmag_q;
    nneg_d      = nneg_q;
    axis_d      = axis_q;
    status_d    = status_q;
    mul_go_d    = 1'b0;
    div_go_d    = 1'b0;
    ema_ph_d    = ema_ph_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    for (int k = 0; k < 3; k++) begin
      smooth_d[k] = smooth_q[k];
      sp_d[k]     = sp_q[k];
      stp_d[k]    = stp_q[k];
      raw_d[k]    = raw_q[k];
      res_d[k]    = res_q[k];
      apos_d[k]   = rd_data.sample_time == 32'd0 ? apos_q[k] : apos_q[k];
      tp_d[k]     = tp_full[k][63:0];
      bpos_d[k]   = apos_q[k];
    end
    apos_d[0] = rd_data.pos_x;
    apos_d[1] = rd_data.pos_y;
    apos_d[2] = rd_data.pos_z;

    // ram read pipeline: data, relative time, products, sums
    r1_v_d     = issue;
    r1_first_d = (issue_q == '0);
    a_v_d      = r1_v_q;
    relt_d     = rd_data.sample_time - base_t;
    b_v_d      = a_v_q;
    brelt_d    = relt_q;
    t2_d       = relt_q * relt_q;
    if (r1_v_q && r1_first_q) begin
      ref_d = rd_data.sample_time;
    end
    if (b_v_q) begin
      st_d  = st_q + ST_W'(brelt_q);
      st2_d = st2_q + T2_W'(t2_q);
      for (int k = 0; k < 3; k++) begin
        sp_d[k]  = sp_q[k] + {{NW{bpos_q[k][31]}}, bpos_q[k]};
        stp_d[k] = stp_q[k] + {{NW{tp_q[k][63]}}, tp_q[k]};
      end
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrv_pkg::CFG_WINDOW: win_d = cfg_wdata_i[wrv_pkg::WIN_W-1:0];
        wrv_pkg::CFG_SMOOTH: sf_d  = cfg_wdata_i[wrv_pkg::SF_W-1:0];
        default: ;
      endcase
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d     = cnt_new;
          wslot_d   = wslot_new;
          issue_d   = '0;
          rd_addr_d = first_tmp[AW-1:0];
          st_d      = '0;
          st2_d     = '0;
          axis_d    = '0;
          ema_ph_d  = 1'b0;
          status_d  = wrv_pkg::STATUS_OK;
          for (int k = 0; k < 3; k++) begin
            sp_d[k]  = '0;
            stp_d[k] = '0;
            raw_d[k] = '0;
          end
          if (cnt_new < NW'(2)) begin
            status_d = wrv_pkg::STATUS_FEW;
            state_d  = S_EMA;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (issue) begin
          issue_d   = issue_q + 1'b1;
          rd_addr_d = (rd_addr_q == AW'(WINDOW_MAX - 1)) ? '0 : rd_addr_q + 1'b1;
        end else if (!r1_v_q && !a_v_q && !b_v_q) begin
          state_d  = S_MUL;
          mop_d    = M_NST2;
          mul_go_d = 1'b1;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          unique case (mop_q)
            M_NST2: begin
              dena_d   = prod;
              mop_d    = M_STST;
              mul_go_d = 1'b1;
            end
            M_STST: begin
              den_d = den_new;
              if (den_new < ACC_W'(wrv_pkg::DEN_MIN)) begin
                status_d = wrv_pkg::STATUS_DEGEN;
                state_d  = S_EMA;
              end else begin
                axis_d   = '0;
                mop_d    = M_NSTP;
                mul_go_d = 1'b1;
              end
            end
            M_NSTP: begin
              term_d   = stp_q[axis_q][T2_W-1] ? -$signed(prod) : $signed(prod);
              mop_d    = M_STSP;
              mul_go_d = 1'b1;
            end
            M_STSP: begin
              nneg_d   = num_new[ACC_W-1];
              nmag_d   = num_new[ACC_W-1] ? ACC_W'(-num_new) : ACC_W'(num_new);
              mop_d    = M_SCALE;
              mul_go_d = 1'b1;
            end
            M_SCALE: begin
              state_d  = S_DIV;
              div_go_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          raw_d[axis_q] = raw_new;
          if (axis_q == 2'd2) begin
            axis_d   = '0;
            ema_ph_d = 1'b0;
            state_d  = S_EMA;
          end else begin
            axis_d   = axis_q + 1'b1;
            mop_d    = M_NSTP;
            mul_go_d = 1'b1;
            state_d  = S_MUL;
          end
        end
      end
      S_EMA: begin
        if (!ema_ph_q) begin
          m1_d     = $signed({1'b0, sf_q}) * smooth_q[axis_q];
          m2_d     = $signed({1'b0, sf_inv}) * raw_q[axis_q];
          ema_ph_d = 1'b1;
        end else begin
          ema_ph_d = 1'b0;
          if (sf_on) begin
            smooth_d[axis_q] = ema_sat;
            res_d[axis_q]    = ema_sat;
          end else begin
            res_d[axis_q] = raw_q[axis_q];
          end
          if (axis_q == 2'd2) begin
            state_d = S_DONE;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.vel_x  = res_q[0];
          out_d.vel_y  = res_q[1];
          out_d.vel_z  = res_q[2];
          out_d.status = status_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mop_q       <= M_NST2;
      win_q       <= wrv_pkg::WIN_RESET;
      sf_q        <= wrv_pkg::SF_RESET;
      cnt_q       <= '0;
      wslot_q     <= '0;
      issue_q     <= '0;
      r1_v_q      <= 1'b0;
      a_v_q       <= 1'b0;
      b_v_q       <= 1'b0;
      mul_go_q    <= 1'b0;
      div_go_q    <= 1'b0;
      axis_q      <= '0;
      ema_ph_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        smooth_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      mop_q       <= mop_d;
      win_q       <= win_d;
      sf_q        <= sf_d;
      cnt_q       <= cnt_d;
      wslot_q     <= wslot_d;
      issue_q     <= issue_d;
      r1_v_q      <= r1_v_d;
      a_v_q       <= a_v_d;
      b_v_q       <= b_v_d;
      mul_go_q    <= mul_go_d;
      div_go_q    <= div_go_d;
      axis_q      <= axis_d;
      ema_ph_q    <= ema_ph_d;
      out_valid_q <= out_valid_d;
      for (int k = 0; k < 3; k++) begin
        smooth_q[k] <= smooth_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q  <= rd_addr_d;
    r1_first_q <= r1_first_d;
    ref_q      <= ref_d;
    relt_q     <= relt_d;
    brelt_q    <= brelt_d;
    t2_q       <= t2_d;
    st_q       <= st_d;
    st2_q      <= st2_d;
    dena_q     <= dena_d;
    den_q      <= den_d;
    term_q     <= term_d;
    nmag_q     <= nmag_d;
    nneg_q     <= nneg_d;
    status_q   <= status_d;
    m1_q       <= m1_d;
    m2_q       <= m2_d;
    out_q      <= out_d;
    for (int k = 0; k < 3; k++) begin
      apos_q[k] <= apos_d[k];
      tp_q[k]   <= tp_d[k];
      bpos_q[k] <= bpos_d[k];
      sp_q[k]   <= sp_d[k];
      stp_q[k]  <= stp_d[k];
      raw_q[k]  <= raw_d[k];
      res_q[k]  <= res_d[k];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
